FILE: hw/rtl/mrc_pkg.sv
// Shared types, constants and the CRC byte-fold function for the Modbus
// response checker. No dependencies.
package mrc_pkg;

	localparam logic [2:0]  FrameLastPos = 3'd6;
	localparam logic [2:0]  PosRegHi     = 3'd3;
	localparam logic [2:0]  PosRegLo     = 3'd4;
	localparam logic [2:0]  PosCrcLo     = 3'd5;
	localparam logic [15:0] CrcStart     = 16'hFFFF;
	localparam logic [15:0] CrcPoly      = 16'hA001;

	// Result of one frame, produced on the last byte
	typedef struct packed {
		logic        done;
		logic [15:0] reading;
		logic        ok;
		logic [15:0] last_good;
	} frame_res_t;

	// Reflected CRC-16 update over one byte, eight shift steps unrolled
	function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] crc;
		crc = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CrcPoly;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

FILE: hw/rtl/mrc_frame_track.sv
// Frame position tracker, running CRC and reading capture.
// Depends on mrc_pkg.
module mrc_frame_track import mrc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] data,
	output logic       is_last,
	output frame_res_t res
);

	logic [2:0]  pos_q;
	logic [15:0] crc_q;
	logic [15:0] reading_q;
	logic [7:0]  crc_lo_q;
	logic [15:0] last_good_q;

	logic [2:0]  pos;
	logic [15:0] crc_base;
	logic [15:0] rx_crc;
	logic        match;

	// Out-of-range position restarts the frame
	assign pos      = (pos_q > FrameLastPos) ? 3'd0 : pos_q;
	assign crc_base = (pos_q > FrameLastPos) ? CrcStart : crc_q;
	assign is_last  = (pos == FrameLastPos);

	// Compare on the last byte; received CRC is low byte first
	assign rx_crc = {data, crc_lo_q};
	assign match  = (rx_crc == crc_base);

	assign res.done      = fire && is_last;
	assign res.reading   = reading_q;
	assign res.ok        = match;
	assign res.last_good = match ? reading_q : last_good_q;

	// Frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 3'd0;
			crc_q       <= CrcStart;
			reading_q   <= 16'h0000;
			crc_lo_q    <= 8'h00;
			last_good_q <= 16'h0000;
		end else if (fire) begin
			if (is_last) begin
				pos_q <= 3'd0;
				crc_q <= CrcStart;
				if (match) begin
					last_good_q <= reading_q;
				end
			end else begin
				pos_q <= pos + 3'd1;
				if (pos <= PosRegLo) begin
					crc_q <= crc_fold(crc_base, data);
				end else begin
					crc_q <= crc_base;
				end
				if (pos == PosRegHi) begin
					reading_q <= {data, 8'h00};
				end else if (pos == PosRegLo) begin
					reading_q <= {reading_q[15:8], data};
				end else if (pos == PosCrcLo) begin
					crc_lo_q <= data;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/modbus_sensor_response_checker_core.sv
// Top level of the Modbus response checker: input register, frame tracker,
// result register. Depends on mrc_pkg and mrc_frame_track.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | rx_byte[7:0]
//  out     | output    | out_valid/out_stall| reading_ppm[15:0], crc_ok, last_good_ppm[15:0]
//
// One byte per cycle while in_stall is low; a last byte accepted into the input
// register passes on to the result register, which then raises out_valid.
// The CRC fold of one byte is combinational logic in the tracker.
// arst_n clears the frame position, CRC and both register valids.
// in_stall rises only when the input register holds the last byte of a
// frame and the result register is full and stalled; other bytes flow on.
module modbus_sensor_response_checker_core import mrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] reading_ppm,
	output logic        crc_ok,
	output logic [15:0] last_good_ppm
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic [15:0] reading_q;
	logic        crc_ok_q;
	logic [15:0] last_good_q;

	logic        is_last;
	logic        out_free;
	logic        adv;
	frame_res_t  res;

	// Advance the held beat unless it makes a result with nowhere to go
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!is_last || out_free);
	assign in_stall = valid_s1 && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	mrc_frame_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (adv),
		.data    (byte_s1),
		.is_last (is_last),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.done;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			reading_q   <= res.reading;
			crc_ok_q    <= res.ok;
			last_good_q <= res.last_good;
		end
	end

	assign out_valid     = out_valid_q;
	assign reading_ppm   = reading_q;
	assign crc_ok        = crc_ok_q;
	assign last_good_ppm = last_good_q;

	// A passing frame reports its own reading as the last good one
	a_ok_last_good: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && crc_ok_q |-> last_good_q == reading_q)
		else $error("last good reading differs on a passing frame");

	// Stall only with a beat held in the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && is_last)
		else $error("input stalled without a pending last byte");

	// A result is loaded only into a free result register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> out_free)
		else $error("result register overwritten while stalled");

endmodule
